// ===== src/tcld_pkg.sv =====
`timescale 1ns / 1ps

package tcld_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int LEN_W      = $clog2(LINE_DEPTH + 1);
    localparam int LIMIT_W    = 6;
    localparam int PADDR_W    = 4;

    localparam logic [7:0] KEY_DEL = 8'h7F;
    localparam logic [7:0] KEY_CR  = 8'h0D;
    localparam logic [7:0] KEY_LF  = 8'h0A;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

    typedef enum logic [1:0] {
        REG_ECHO_ENABLE    = 2'd0,
        REG_IN_NL_TO_CRNL  = 2'd1,
        REG_OUT_NL_TO_CRNL = 2'd2,
        REG_LINE_LIMIT     = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       to_reader;
        logic       last;
    } out_item_t;

    function automatic logic [LEN_W-1:0] eff_limit(input logic [LIMIT_W-1:0] lim);
        logic [LEN_W-1:0] res;
        if (lim == '0) begin
            res = LEN_W'(1);
        end else if ({1'b0, lim} > (LIMIT_W + 1)'(LINE_DEPTH)) begin
            res = LEN_W'(LINE_DEPTH);
        end else begin
            res = LEN_W'(lim);
        end
        return res;
    endfunction

endpackage

// ===== src/tcld_line_ram.sv =====
`timescale 1ns / 1ps

module tcld_line_ram
    import tcld_pkg::*;
(
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [LINE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tcld_out_reg.sv =====
`timescale 1ns / 1ps

module tcld_out_reg
    import tcld_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  out_item_t item,
    output logic      free,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (push) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            item_reg <= item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

// ===== src/tty_cooked_line_discipline.sv =====
`timescale 1ns / 1ps
// Cooked terminal line discipline.
// Input channel s_*: one key byte per item. Result channel m_*: echo bytes
// (to_reader 0) followed, when a line completes, by the stored line bytes
// (to_reader 1); last marks the final result caused by one key byte.
// Configuration over the APB port: echo_enable at 0x0, in_nl_to_crnl at 0x4,
// out_nl_to_crnl at 0x8, line_limit at 0xC; write only while idle.
// Timing: the key byte is written to the line RAM in the accept cycle (a CR LF
// pair writes its LF in the next cycle). The echo bytes go out first, then the
// line is read out of the single-port-read RAM through its registered read port
// at one byte per cycle while the output register is free; the
// next key byte is taken once the last result of the previous one is loaded
// into the output register. A DEL on an empty line produces no result.
// Reset clears the line length and sets the registers to echo on, both newline
// translations on and a line limit of 32; the line RAM needs no clearing.
// When m_ready is low the output register holds its item and the sequencer
// stalls; nothing is dropped.
module tty_cooked_line_discipline
    import tcld_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_key_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_to_reader,
    output logic               m_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_ECHO_CR = 4'b0010,
        ST_ECHO_CH = 4'b0100,
        ST_DELIVER = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic               echo_en_reg, in_nl_reg, out_nl_reg;
    logic [LIMIT_W-1:0] limit_reg;
    reg_index_t         widx;

    logic [LEN_W-1:0]  line_len_reg, line_len_next;
    logic [LEN_W-1:0]  dlv_len_reg, dlv_len_next;
    logic [LEN_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [LEN_W-1:0]  snd_idx_reg, snd_idx_next;
    logic              rv_reg, rv_next;
    logic              dlv_reg, dlv_next;
    logic [7:0]        ch_reg, ch_next;
    logic              lf_pend_reg, lf_pend_next;
    logic [ADDR_W-1:0] lf_addr_reg, lf_addr_next;

    logic              accept;
    logic              is_del, is_cr, is_lf, has_room, cr_ok;
    logic [LEN_W-1:0]  lim_eff, len_final;
    logic              deliver;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata, ram_rdata;

    logic              out_free, push, push_dlv;
    out_item_t         push_item, m_item;

    // configuration
    assign pready = 1'b1;
    assign widx   = reg_index_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_en_reg <= 1'b1;
            in_nl_reg   <= 1'b1;
            out_nl_reg  <= 1'b1;
            limit_reg   <= LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            case (widx)
                REG_ECHO_ENABLE:    echo_en_reg <= pwdata[0];
                REG_IN_NL_TO_CRNL:  in_nl_reg   <= pwdata[0];
                REG_OUT_NL_TO_CRNL: out_nl_reg  <= pwdata[0];
                REG_LINE_LIMIT:     limit_reg   <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (widx)
            REG_ECHO_ENABLE:    prdata = {31'd0, echo_en_reg};
            REG_IN_NL_TO_CRNL:  prdata = {31'd0, in_nl_reg};
            REG_OUT_NL_TO_CRNL: prdata = {31'd0, out_nl_reg};
            REG_LINE_LIMIT:     prdata = {{(32 - LIMIT_W){1'b0}}, limit_reg};
            default:            prdata = '0;
        endcase
    end

    // key decode
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_del   = (s_key_byte == KEY_DEL);
    assign is_cr    = (s_key_byte == KEY_CR);
    assign is_lf    = (s_key_byte == KEY_LF);
    assign lim_eff  = eff_limit(limit_reg);
    assign has_room = ({1'b0, line_len_reg} < (LEN_W + 1)'(LINE_DEPTH));
    assign cr_ok    = is_lf && in_nl_reg
                      && (({1'b0, line_len_reg} + (LEN_W + 1)'(1)) < {1'b0, lim_eff});

    always_comb begin
        if (is_del) begin
            len_final = line_len_reg - LEN_W'(1);
        end else if (cr_ok) begin
            len_final = line_len_reg + LEN_W'(2);
        end else if (has_room) begin
            len_final = line_len_reg + LEN_W'(1);
        end else begin
            len_final = line_len_reg;
        end
    end

    assign deliver = is_cr || is_lf || (len_final >= lim_eff);

    // line RAM write port: key byte (or CR for an expanded LF) on accept, trailing LF in the next cycle
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = line_len_reg[ADDR_W-1:0];
        ram_wdata = cr_ok ? KEY_CR : s_key_byte;
        if (lf_pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = lf_addr_reg;
            ram_wdata = KEY_LF;
        end else if (accept && !is_del && has_room) begin
            ram_we = 1'b1;
        end
    end

    // line read-out
    assign push_dlv = (state_reg == ST_DELIVER) && rv_reg && out_free;
    assign ram_re   = (state_reg == ST_DELIVER) && (rd_idx_reg < dlv_len_reg)
                      && (!rv_reg || push_dlv);

    always_comb begin
        state_next    = state_reg;
        line_len_next = line_len_reg;
        dlv_len_next  = dlv_len_reg;
        rd_idx_next   = rd_idx_reg;
        snd_idx_next  = snd_idx_reg;
        rv_next       = rv_reg;
        dlv_next      = dlv_reg;
        ch_next       = ch_reg;
        lf_pend_next  = 1'b0;
        lf_addr_next  = lf_addr_reg;
        push          = 1'b0;
        push_item     = '{out_byte: KEY_CR, to_reader: 1'b0, last: 1'b0};

        case (state_reg)
            ST_IDLE: begin
                if (accept && !(is_del && line_len_reg == '0)) begin
                    ch_next       = s_key_byte;
                    dlv_next      = deliver;
                    dlv_len_next  = len_final;
                    line_len_next = deliver ? '0 : len_final;
                    lf_pend_next  = cr_ok;
                    lf_addr_next  = ADDR_W'(line_len_reg + LEN_W'(1));
                    rd_idx_next   = '0;
                    snd_idx_next  = '0;
                    rv_next       = 1'b0;
                    if (echo_en_reg && is_lf && out_nl_reg) begin
                        state_next = ST_ECHO_CR;
                    end else if (echo_en_reg) begin
                        state_next = ST_ECHO_CH;
                    end else if (deliver) begin
                        state_next = ST_DELIVER;
                    end
                end
            end
            ST_ECHO_CR: begin
                if (out_free) begin
                    push       = 1'b1;
                    state_next = ST_ECHO_CH;
                end
            end
            ST_ECHO_CH: begin
                push_item = '{out_byte: ch_reg, to_reader: 1'b0, last: !dlv_reg};
                if (out_free) begin
                    push       = 1'b1;
                    state_next = dlv_reg ? ST_DELIVER : ST_IDLE;
                end
            end
            ST_DELIVER: begin
                push_item = '{out_byte: ram_rdata, to_reader: 1'b1,
                              last: (snd_idx_reg == dlv_len_reg - LEN_W'(1))};
                if (ram_re) begin
                    rd_idx_next = rd_idx_reg + LEN_W'(1);
                    rv_next     = 1'b1;
                end else if (push_dlv) begin
                    rv_next = 1'b0;
                end
                if (push_dlv) begin
                    push         = 1'b1;
                    snd_idx_next = snd_idx_reg + LEN_W'(1);
                    if (push_item.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            line_len_reg <= '0;
            rv_reg       <= 1'b0;
            lf_pend_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            line_len_reg <= line_len_next;
            rv_reg       <= rv_next;
            lf_pend_reg  <= lf_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        dlv_len_reg <= dlv_len_next;
        rd_idx_reg  <= rd_idx_next;
        snd_idx_reg <= snd_idx_next;
        dlv_reg     <= dlv_next;
        ch_reg      <= ch_next;
        lf_addr_reg <= lf_addr_next;
    end

    tcld_line_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    tcld_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .item    (push_item),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    assign m_out_byte  = m_item.out_byte;
    assign m_to_reader = m_item.to_reader;
    assign m_last      = m_item.last;

endmodule

// ===== tb/tb_tty_cooked_line_discipline.sv =====
`timescale 1ns / 1ps

module tb_tty_cooked_line_discipline;
    import tcld_pkg::*;

    localparam int CYCLE_LIMIT  = 1_200_000;
    localparam int DRAIN_CYCLES = LINE_DEPTH + 8;
    localparam int LONG_HOLD    = 300;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [7:0]         s_key_byte  = 8'h00;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [7:0]         m_out_byte;
    logic               m_to_reader;
    logic               m_last;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [31:0]        pwdata      = '0;
    logic [31:0]        prdata;
    logic               pready;

    tty_cooked_line_discipline u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_key_byte  (s_key_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_to_reader (m_to_reader),
        .m_last      (m_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    logic [7:0]       key_bytes_q[$];
    out_item_t        cooked_out_q[$];

    logic [7:0]       held_line[LINE_DEPTH];
    int               held_len      = 0;
    logic             echo_on       = 1'b1;
    logic             nl_in_crlf    = 1'b1;
    logic             nl_echo_crlf  = 1'b1;
    logic [LIMIT_W-1:0] limit_reg   = LIMIT_RESET;

    int               mismatches    = 0;
    int               cycle_count   = 0;
    int               tx_gap        = 0;
    int               rx_gap        = 0;
    int               rx_hold_left  = 0;
    int               hold_requests = 0;
    int               holds_served  = 0;
    logic             idle_on       = 1'b1;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic void hold_byte(input logic [7:0] b);
        if (held_len < LINE_DEPTH) begin
            held_line[held_len] = b;
            held_len++;
        end
    endfunction

    function automatic void cook_key_byte(input logic [7:0] ch);
        out_item_t burst[$];
        int        lim;
        lim = int'(limit_reg);
        if (lim == 0) lim = 1;
        if (lim > LINE_DEPTH) lim = LINE_DEPTH;

        if (ch == KEY_DEL) begin
            if (held_len == 0) return;
            held_len--;
        end else if (ch == KEY_LF) begin
            if (nl_in_crlf && held_len + 1 < lim) hold_byte(KEY_CR);
            hold_byte(KEY_LF);
        end else begin
            hold_byte(ch);
        end

        if (echo_on) begin
            if (ch == KEY_LF && nl_echo_crlf) begin
                burst.push_back('{out_byte: KEY_CR, to_reader: 1'b0, last: 1'b0});
            end
            burst.push_back('{out_byte: ch, to_reader: 1'b0, last: 1'b0});
        end

        if (ch == KEY_CR || ch == KEY_LF || held_len >= lim) begin
            for (int i = 0; i < held_len; i++) begin
                burst.push_back('{out_byte: held_line[i], to_reader: 1'b1, last: 1'b0});
            end
            held_len = 0;
        end

        if (burst.size() > 0) begin
            burst[burst.size() - 1].last = 1'b1;
        end
        foreach (burst[i]) cooked_out_q.push_back(burst[i]);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap  <= 0;
        end else if (!s_valid || s_ready) begin
            if (tx_gap > 0) begin
                s_valid <= 1'b0;
                tx_gap  <= tx_gap - 1;
            end else if (key_bytes_q.size() > 0) begin
                s_valid    <= 1'b1;
                s_key_byte <= key_bytes_q.pop_front();
                tx_gap     <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            rx_hold_left <= LONG_HOLD;
            m_ready      <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_ready      <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap  <= rx_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            rx_gap  <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (cooked_out_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected item: byte %02h reader %0b last %0b",
                                 m_out_byte, m_to_reader, m_last);
                    end
                end else begin
                    want = cooked_out_q.pop_front();
                    if (m_out_byte !== want.out_byte || m_to_reader !== want.to_reader ||
                        m_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected byte %02h reader %0b last %0b,",
                                     want.out_byte, want.to_reader, want.last,
                                     " got byte %02h reader %0b last %0b",
                                     m_out_byte, m_to_reader, m_last);
                        end
                    end
                end
            end
            if (s_valid && s_ready) cook_key_byte(s_key_byte);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic apb_write(input reg_index_t idx, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ECHO_ENABLE:    echo_on      = data[0];
            REG_IN_NL_TO_CRNL:  nl_in_crlf   = data[0];
            REG_OUT_NL_TO_CRNL: nl_echo_crlf = data[0];
            REG_LINE_LIMIT:     limit_reg    = data[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (key_bytes_q.size() != 0 || s_valid || cooked_out_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [7:0] random_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return KEY_DEL;
        if (r < 18) return KEY_LF;
        if (r < 23) return KEY_CR;
        if (r < 33) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    function automatic logic [31:0] noisy_bit(input logic b);
        return ($urandom() & ~32'h1) | 32'(b);
    endfunction

    initial begin
        int lim;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: DEL on stored and empty lines, both terminators
        key_bytes_q.push_back(8'h61);  key_bytes_q.push_back(8'h00);
        key_bytes_q.push_back(8'hFF);  key_bytes_q.push_back(KEY_DEL);
        key_bytes_q.push_back(8'h80);  key_bytes_q.push_back(KEY_LF);
        key_bytes_q.push_back(KEY_DEL); key_bytes_q.push_back(KEY_CR);
        wait_idle();

        // line full at the limit, then LF with room for one byte only
        apb_write(REG_LINE_LIMIT, 32'd3);
        key_bytes_q.push_back(8'h78);  key_bytes_q.push_back(8'h79);
        key_bytes_q.push_back(8'h7A);  key_bytes_q.push_back(8'h70);
        key_bytes_q.push_back(8'h71);  key_bytes_q.push_back(KEY_LF);
        wait_idle();

        // everything off, limit of zero
        apb_write(REG_ECHO_ENABLE, 32'd0);
        apb_write(REG_IN_NL_TO_CRNL, 32'd0);
        apb_write(REG_OUT_NL_TO_CRNL, 32'd0);
        apb_write(REG_LINE_LIMIT, 32'd0);
        key_bytes_q.push_back(8'h6B);  key_bytes_q.push_back(KEY_LF);
        key_bytes_q.push_back(KEY_DEL);
        wait_idle();

        // limit above the store, then lowered under a held line
        apb_write(REG_ECHO_ENABLE, 32'hFFFF_FFFF);
        apb_write(REG_IN_NL_TO_CRNL, 32'd1);
        apb_write(REG_LINE_LIMIT, 32'hFFFF_FFFF);
        key_bytes_q.push_back(8'h31);  key_bytes_q.push_back(8'h32);
        key_bytes_q.push_back(8'h33);
        wait_idle();
        apb_write(REG_LINE_LIMIT, 32'd2);
        key_bytes_q.push_back(8'h34);  key_bytes_q.push_back(KEY_LF);
        wait_idle();

        for (int phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 5))
                0:       lim = 0;
                1:       lim = 1;
                2:       lim = 32;
                3:       lim = $urandom_range(33, 63);
                default: lim = $urandom_range(2, 16);
            endcase
            apb_write(REG_ECHO_ENABLE, noisy_bit(phase != 3));
            apb_write(REG_IN_NL_TO_CRNL, noisy_bit(1'($urandom_range(0, 1))));
            apb_write(REG_OUT_NL_TO_CRNL, noisy_bit(1'($urandom_range(0, 1))));
            apb_write(REG_LINE_LIMIT, ($urandom() & ~32'h3F) | 32'(lim));
            idle_on = (phase != 2);
            repeat (20) key_bytes_q.push_back(random_key());
            wait_idle();
        end

        // stall the receiver while keys keep coming
        idle_on = 1'b1;
        apb_write(REG_ECHO_ENABLE, 32'd1);
        apb_write(REG_LINE_LIMIT, 32'd32);
        hold_requests++;
        repeat (40) key_bytes_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        key_bytes_q.push_back(KEY_LF);
        wait_idle();

        if (mismatches == 0 && cooked_out_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
